// ===== hw/rtl/glr_pkg.sv =====
// Shared constants and types for the gradient line rasterizer.
package glr_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int RATIO_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CH_BITS        = 8;
    localparam int COLOR_BITS     = 24;
    localparam int OFS_BITS       = 16;
    localparam int DIM_BITS       = 14;

    localparam logic [1:0] REG_PAN_X         = 2'd0;
    localparam logic [1:0] REG_PAN_Y         = 2'd1;
    localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd2;
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd3;

    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 14'd1920;
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 14'd1080;

    typedef struct packed {
        logic signed [OFS_BITS-1:0] pan_x;
        logic signed [OFS_BITS-1:0] pan_y;
        logic [DIM_BITS-1:0]        screen_width;
        logic [DIM_BITS-1:0]        screen_height;
    } t_cfg;

endpackage

// ===== hw/rtl/glr_fifo.sv =====
// Short register queue between the line stepper and the color unit.
module glr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = glr_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule

// ===== hw/rtl/glr_front.sv =====
// Line stepper: takes load and step words, walks the line and queues pixel jobs.
module glr_front #(
    parameter int COORD_BITS = glr_pkg::COORD_BITS_DEF,
    parameter int JOB_BITS   = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic                         i_mode,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_stop_x,
    input  logic signed [COORD_BITS-1:0] i_stop_y,
    input  logic [23:0]                  i_start_color,
    input  logic [23:0]                  i_stop_color,
    input  glr_pkg::t_cfg                i_cfg,
    output logic                         o_job_push,
    output logic [JOB_BITS-1:0]          o_job
);
    localparam int C  = COORD_BITS;
    localparam int EW = C + 3;
    localparam int SW = ((C > glr_pkg::OFS_BITS) ? C : glr_pkg::OFS_BITS) + 1;

    logic signed [C-1:0]  r_cur_x, r_cur_y, r_beg_x, r_beg_y, r_end_x, r_end_y;
    logic signed [EW-1:0] r_err;
    logic [C:0]           r_adx, r_ady;
    logic                 r_sx, r_sy, r_active;
    logic [23:0]          r_sc, r_ec;

    logic signed [C:0]    w_dx, w_dy, w_mx, w_my;
    logic [C:0]           w_adx, w_ady, w_amx, w_amy;
    logic signed [EW:0]   w_e2;
    logic                 w_cx, w_cy, w_at_end, w_go, w_last, w_vis;
    logic signed [C-1:0]  w_nx, w_ny;
    logic signed [EW-1:0] w_nerr;
    logic signed [SW-1:0] w_px, w_py;

    // Load-time deltas.
    assign w_dx  = $signed({i_stop_x[C-1], i_stop_x}) - $signed({i_start_x[C-1], i_start_x});
    assign w_dy  = $signed({i_stop_y[C-1], i_stop_y}) - $signed({i_start_y[C-1], i_start_y});
    assign w_adx = w_dx[C] ? (C+1)'(-w_dx) : (C+1)'(w_dx);
    assign w_ady = w_dy[C] ? (C+1)'(-w_dy) : (C+1)'(w_dy);

    // One Bresenham step from the current point.
    assign w_at_end = (r_cur_x == r_end_x) && (r_cur_y == r_end_y);
    assign w_go     = i_accept && i_mode && r_active && !w_at_end;
    assign w_e2     = {r_err, 1'b0};
    assign w_cx     = w_e2 > -$signed({3'b000, r_ady});
    assign w_cy     = w_e2 < $signed({3'b000, r_adx});
    assign w_nx     = w_cx ? (r_sx ? r_cur_x + 1'b1 : r_cur_x - 1'b1) : r_cur_x;
    assign w_ny     = w_cy ? (r_sy ? r_cur_y + 1'b1 : r_cur_y - 1'b1) : r_cur_y;
    assign w_nerr   = r_err - (w_cx ? $signed({2'b00, r_ady}) : $signed(EW'(0)))
                            + (w_cy ? $signed({2'b00, r_adx}) : $signed(EW'(0)));
    assign w_last   = (w_nx == r_end_x) && (w_ny == r_end_y);

    // Distance of the current pixel from the begin point.
    assign w_mx  = $signed({r_cur_x[C-1], r_cur_x}) - $signed({r_beg_x[C-1], r_beg_x});
    assign w_my  = $signed({r_cur_y[C-1], r_cur_y}) - $signed({r_beg_y[C-1], r_beg_y});
    assign w_amx = w_mx[C] ? (C+1)'(-w_mx) : (C+1)'(w_mx);
    assign w_amy = w_my[C] ? (C+1)'(-w_my) : (C+1)'(w_my);

    // Screen position and clipping.
    assign w_px = $signed({{(SW-C){r_cur_x[C-1]}}, r_cur_x})
                + $signed({{(SW-glr_pkg::OFS_BITS){i_cfg.pan_x[glr_pkg::OFS_BITS-1]}},
                           i_cfg.pan_x});
    assign w_py = $signed({{(SW-C){r_cur_y[C-1]}}, r_cur_y})
                + $signed({{(SW-glr_pkg::OFS_BITS){i_cfg.pan_y[glr_pkg::OFS_BITS-1]}},
                           i_cfg.pan_y});
    assign w_vis = (w_px > 0) && (w_py > 0)
                && (w_px < $signed({{(SW-glr_pkg::DIM_BITS){1'b0}}, i_cfg.screen_width}))
                && (w_py < $signed({{(SW-glr_pkg::DIM_BITS){1'b0}}, i_cfg.screen_height}));

    assign o_job_push = w_go;
    assign o_job = {w_amx, w_amy, r_adx, r_ady, w_px[C:0], w_py[C:0], w_vis, w_last,
                    r_sc, r_ec};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_accept && !i_mode) begin
            r_active <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && !i_mode) begin
            r_beg_x <= i_start_x;
            r_beg_y <= i_start_y;
            r_end_x <= i_stop_x;
            r_end_y <= i_stop_y;
            r_cur_x <= i_start_x;
            r_cur_y <= i_start_y;
            r_adx   <= w_adx;
            r_ady   <= w_ady;
            r_err   <= $signed({2'b00, w_adx}) - $signed({2'b00, w_ady});
            r_sx    <= i_start_x < i_stop_x;
            r_sy    <= i_start_y < i_stop_y;
            r_sc    <= i_start_color;
            r_ec    <= i_stop_color;
        end else if (w_go) begin
            r_cur_x <= w_nx;
            r_cur_y <= w_ny;
            r_err   <= w_nerr;
        end
    end
endmodule

// ===== hw/rtl/glr_back.sv =====
// Color unit: distance ratio by long division and square root, then channel blend.
module glr_back #(
    parameter int COORD_BITS = glr_pkg::COORD_BITS_DEF,
    parameter int RATIO_BITS = glr_pkg::RATIO_BITS_DEF,
    parameter int JOB_BITS   = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_valid,
    input  logic [JOB_BITS-1:0]        i_job,
    output logic                       o_job_pop,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic signed [COORD_BITS:0] o_pixel_x,
    output logic signed [COORD_BITS:0] o_pixel_y,
    output logic [23:0]                o_pixel_color,
    output logic                       o_visible,
    output logic                       o_last
);
    localparam int C   = COORD_BITS;
    localparam int R   = RATIO_BITS;
    localparam int SQW = 2 * (C + 1);
    localparam int DW  = SQW + 1;
    localparam int QW  = 2 * R;
    localparam int NW  = QW + 1;
    localparam int CW  = $clog2(QW);
    localparam int PRW = glr_pkg::CH_BITS + R + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SQ   = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_SQRT = 3'd5;
    localparam logic [2:0] S_MUL  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]     r_state;
    logic           r_ov;
    logic [C:0]     r_amx, r_amy, r_adx, r_ady, r_px, r_py;
    logic           r_vis, r_last;
    logic [23:0]    r_sc, r_ec;
    logic [SQW-1:0] r_sqa, r_sqb, r_sqc, r_sqd;
    logic [DW:0]    r_rem;
    logic [DW-1:0]  r_dt;
    logic [QW-1:0]  r_q;
    logic [NW-1:0]  r_n, r_res, r_bit;
    logic [CW-1:0]  r_cnt;
    logic [R:0]     r_ratio;
    logic [PRW-1:0] r_prod [3];

    logic [DW:0]    w_rem2;
    logic           w_take;
    logic [QW-1:0]  w_q;
    logic [NW-1:0]  w_sum;
    logic           w_ge;
    logic [NW-1:0]  w_res;
    logic [23:0]    w_color;
    logic           w_load_out;

    assign w_rem2 = {r_rem[DW-1:0], 1'b0};
    assign w_take = w_rem2 >= {1'b0, r_dt};
    assign w_q    = {r_q[QW-2:0], w_take};
    assign w_sum  = r_res + r_bit;
    assign w_ge   = r_n >= w_sum;
    assign w_res  = w_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);

    // Each channel moves from the start color toward the stop color by the scaled gap.
    always_comb begin
        logic [glr_pkg::CH_BITS-1:0] sc, ec, mag;
        w_color = '0;
        for (int i = 0; i < 3; i++) begin
            sc  = r_sc[i*glr_pkg::CH_BITS +: glr_pkg::CH_BITS];
            ec  = r_ec[i*glr_pkg::CH_BITS +: glr_pkg::CH_BITS];
            mag = r_prod[i][R +: glr_pkg::CH_BITS];
            w_color[i*glr_pkg::CH_BITS +: glr_pkg::CH_BITS] = (sc < ec) ? sc + mag : sc - mag;
        end
    end

    assign o_job_pop  = (r_state == S_IDLE) && i_job_valid;
    assign w_load_out = (r_state == S_OUT) && (!r_ov || i_pop);
    assign o_empty    = !r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_ov <= 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (i_job_valid) r_state <= S_SQ;
                S_SQ:   r_state <= S_SUM;
                S_SUM:  r_state <= S_CHK;
                S_CHK: begin
                    if (r_dt == '0 || r_rem >= {1'b0, r_dt}) begin
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV:  if (r_cnt == CW'(QW - 1)) r_state <= S_SQRT;
                S_SQRT: if (r_cnt == CW'(R - 1)) r_state <= S_MUL;
                S_MUL:  r_state <= S_OUT;
                S_OUT:  if (w_load_out) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                {r_amx, r_amy, r_adx, r_ady, r_px, r_py, r_vis, r_last, r_sc, r_ec} <= i_job;
            end
            S_SQ: begin
                r_sqa <= r_amx * r_amx;
                r_sqb <= r_amy * r_amy;
                r_sqc <= r_adx * r_adx;
                r_sqd <= r_ady * r_ady;
            end
            S_SUM: begin
                r_rem <= (DW+1)'(r_sqa) + (DW+1)'(r_sqb);
                r_dt  <= DW'(r_sqc) + DW'(r_sqd);
                r_q   <= '0;
                r_cnt <= '0;
            end
            S_CHK: begin
                if (r_dt == '0) begin
                    r_ratio <= '0;
                end else begin
                    r_ratio <= (R+1)'(1) << R;
                end
            end
            S_DIV: begin
                r_rem <= w_take ? w_rem2 - {1'b0, r_dt} : w_rem2;
                r_q   <= w_q;
                if (r_cnt == CW'(QW - 1)) begin
                    r_n   <= NW'(w_q);
                    r_res <= '0;
                    r_bit <= NW'(1) << (QW - 2);
                    r_cnt <= '0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            S_SQRT: begin
                if (w_ge) begin
                    r_n <= r_n - w_sum;
                end
                r_res <= w_res;
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(R - 1)) begin
                    r_ratio <= w_res[R:0];
                end
            end
            S_MUL: begin
                for (int i = 0; i < 3; i++) begin
                    logic [glr_pkg::CH_BITS-1:0] a, b, d;
                    a = r_sc[i*glr_pkg::CH_BITS +: glr_pkg::CH_BITS];
                    b = r_ec[i*glr_pkg::CH_BITS +: glr_pkg::CH_BITS];
                    d = (a < b) ? b - a : a - b;
                    r_prod[i] <= d * r_ratio;
                end
            end
            default: ;
        endcase
        if (w_load_out) begin
            o_pixel_x     <= r_px;
            o_pixel_y     <= r_py;
            o_pixel_color <= w_color;
            o_visible     <= r_vis;
            o_last        <= r_last;
        end
    end
endmodule

// ===== hw/rtl/gradient_line_rasterizer_core.sv =====
// A load word only sets up the line walk. A pixel job passes through the color unit
// states square, sum, check, division, square root, multiply and output; the division
// and square root are skipped when the distance ratio clamps at one or the line has zero
// length. The color unit runs one pixel at a time and takes no new job before the last one is in the output register.
// Reset is synchronous and active low: it clears the queue, the line walk and the
// output register, and loads the register defaults (offsets 0, screen 1920 by 1080).
module gradient_line_rasterizer_core #(
    parameter int COORD_BITS = glr_pkg::COORD_BITS_DEF,
    parameter int RATIO_BITS = glr_pkg::RATIO_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [3:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // Input words.
    input  logic                         push,
    output logic                         full,
    input  logic                         i_mode,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_stop_x,
    input  logic signed [COORD_BITS-1:0] i_stop_y,
    input  logic [23:0]                  i_start_color,
    input  logic [23:0]                  i_stop_color,
    // Result words.
    output logic                         empty,
    input  logic                         pop,
    output logic signed [COORD_BITS:0]   o_pixel_x,
    output logic signed [COORD_BITS:0]   o_pixel_y,
    output logic [23:0]                  o_pixel_color,
    output logic                         o_visible,
    output logic                         o_last
);
    // A job carries both distances, both line deltas, the screen point, the
    // clip and end flags, and both colors.
    localparam int JOB_BITS = 6 * (COORD_BITS + 1) + 2 + 2 * glr_pkg::COLOR_BITS;

    glr_pkg::t_cfg       r_cfg;
    logic                w_accept;
    logic                w_job_push, w_job_pop, w_q_full, w_q_empty;
    logic [JOB_BITS-1:0] w_job_in, w_job_out;
    logic [1:0]          w_idx;

    // The register file is written at the access phase of a write.
    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pan_x         <= '0;
            r_cfg.pan_y         <= '0;
            r_cfg.screen_width  <= glr_pkg::WIDTH_RESET;
            r_cfg.screen_height <= glr_pkg::HEIGHT_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                glr_pkg::REG_PAN_X:         r_cfg.pan_x         <= pwdata[15:0];
                glr_pkg::REG_PAN_Y:         r_cfg.pan_y         <= pwdata[15:0];
                glr_pkg::REG_SCREEN_WIDTH:  r_cfg.screen_width  <= pwdata[13:0];
                glr_pkg::REG_SCREEN_HEIGHT: r_cfg.screen_height <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            glr_pkg::REG_PAN_X:         prdata = {16'd0, r_cfg.pan_x};
            glr_pkg::REG_PAN_Y:         prdata = {16'd0, r_cfg.pan_y};
            glr_pkg::REG_SCREEN_WIDTH:  prdata = {18'd0, r_cfg.screen_width};
            glr_pkg::REG_SCREEN_HEIGHT: prdata = {18'd0, r_cfg.screen_height};
            default:                    prdata = '0;
        endcase
    end

    // The stepper takes a word whenever the job queue has room, so load words and
    // finished steps flow on while the color unit is still busy.
    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    glr_front #(
        .COORD_BITS(COORD_BITS),
        .JOB_BITS  (JOB_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_mode       (i_mode),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_stop_x     (i_stop_x),
        .i_stop_y     (i_stop_y),
        .i_start_color(i_start_color),
        .i_stop_color (i_stop_color),
        .i_cfg        (r_cfg),
        .o_job_push   (w_job_push),
        .o_job        (w_job_in)
    );

    glr_fifo #(
        .WIDTH(JOB_BITS),
        .DEPTH(glr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_job_push),
        .i_data (w_job_in),
        .o_full (w_q_full),
        .i_pop  (w_job_pop),
        .o_empty(w_q_empty),
        .o_data (w_job_out)
    );

    // The color unit drains the queue one job at a time into its output register.
    glr_back #(
        .COORD_BITS(COORD_BITS),
        .RATIO_BITS(RATIO_BITS),
        .JOB_BITS  (JOB_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (!w_q_empty),
        .i_job        (w_job_out),
        .o_job_pop    (w_job_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_pixel_color(o_pixel_color),
        .o_visible    (o_visible),
        .o_last       (o_last)
    );
endmodule

// ===== dv/glr_line_checker.sv =====
// Line walk predictor and pixel word checker for the gradient line rasterizer.
module glr_line_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [3:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic               i_push,
    input  logic               i_full,
    input  logic               i_mode,
    input  logic signed [15:0] i_start_x,
    input  logic signed [15:0] i_start_y,
    input  logic signed [15:0] i_stop_x,
    input  logic signed [15:0] i_stop_y,
    input  logic [23:0]        i_start_color,
    input  logic [23:0]        i_stop_color,
    input  logic               i_empty,
    input  logic               i_pop,
    input  logic signed [16:0] i_pixel_x,
    input  logic signed [16:0] i_pixel_y,
    input  logic [23:0]        i_pixel_color,
    input  logic               i_visible,
    input  logic               i_last,
    output int                 o_pending,
    output int                 o_errors
);
    typedef longint unsigned t_u64;

    typedef struct packed {
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic [23:0]        color;
        logic               visible;
        logic               last;
    } t_pixel;

    t_pixel pixel_q[$];

    // Screen setup, mirrored from the register writes seen on the port.
    longint ofs_x, ofs_y, scr_w, scr_h;
    // Line walk state.
    longint walk_x, walk_y, org_x, org_y, end_x, end_y, err_term;
    t_u64 col_from, col_to, line_len_sq;
    bit line_loaded;

    assign o_pending = pixel_q.size();

    function automatic t_u64 int_sqrt(t_u64 n);
        t_u64 res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Q16 ratio of distance walked to whole line length.
    function automatic t_u64 walk_ratio(t_u64 dm2, t_u64 dt2);
        t_u64 q, rem;
        q = 0;
        rem = dm2;
        if (dt2 == 0) return 0;
        if (rem >= dt2) return 64'd1 << 16;
        for (int i = 0; i < 32; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= dt2) begin
                rem = rem - dt2;
                q = q | 64'd1;
            end
        end
        q = int_sqrt(q);
        if (q > (64'd1 << 16)) q = 64'd1 << 16;
        return q;
    endfunction

    function automatic logic [23:0] mix_color(t_u64 s, t_u64 e, t_u64 ratio);
        logic [23:0] c;
        longint sc, ec, d, mag, v;
        c = '0;
        for (int ch = 0; ch < 3; ch++) begin
            sc = longint'((s >> (8 * ch)) & 64'hFF);
            ec = longint'((e >> (8 * ch)) & 64'hFF);
            d = sc - ec;
            mag = longint'((t_u64'(d < 0 ? -d : d) * ratio) >> 16);
            v = d < 0 ? sc + mag : sc - mag;
            c[8*ch +: 8] = v[7:0];
        end
        return c;
    endfunction

    // Applies one accepted word to the walk and queues the pixel it makes, if any.
    function automatic void take_word();
        longint dx, dy, e2, mx, my, px, py;
        t_pixel p;
        if (i_mode == 1'b0) begin
            org_x = longint'(i_start_x);
            org_y = longint'(i_start_y);
            end_x = longint'(i_stop_x);
            end_y = longint'(i_stop_y);
            col_from = t_u64'(i_start_color);
            col_to = t_u64'(i_stop_color);
            dx = end_x > org_x ? end_x - org_x : org_x - end_x;
            dy = end_y > org_y ? end_y - org_y : org_y - end_y;
            line_len_sq = t_u64'(dx * dx) + t_u64'(dy * dy);
            err_term = dx - dy;
            walk_x = org_x;
            walk_y = org_y;
            line_loaded = 1'b1;
            return;
        end
        // Steps before a load or past the end point make no pixel.
        if (!line_loaded || (walk_x == end_x && walk_y == end_y)) return;
        mx = walk_x - org_x;
        my = walk_y - org_y;
        p.color = mix_color(col_from, col_to,
            walk_ratio(t_u64'(mx * mx) + t_u64'(my * my), line_len_sq));
        px = walk_x + ofs_x;
        py = walk_y + ofs_y;
        p.visible = px > 0 && py > 0 && px < scr_w && py < scr_h;
        p.x = px[16:0];
        p.y = py[16:0];
        dx = end_x > org_x ? end_x - org_x : org_x - end_x;
        dy = end_y > org_y ? end_y - org_y : org_y - end_y;
        e2 = err_term * 2;
        if (e2 > -dy) begin
            err_term -= dy;
            walk_x += (org_x < end_x) ? 64'sd1 : -64'sd1;
        end
        if (e2 < dx) begin
            err_term += dx;
            walk_y += (org_y < end_y) ? 64'sd1 : -64'sd1;
        end
        p.last = (walk_x == end_x && walk_y == end_y);
        pixel_q.push_back(p);
    endfunction

    always @(posedge i_clk) begin
        t_pixel want;
        if (!i_rst_n) begin
            ofs_x = 0;
            ofs_y = 0;
            scr_w = longint'(glr_pkg::WIDTH_RESET);
            scr_h = longint'(glr_pkg::HEIGHT_RESET);
            walk_x = 0; walk_y = 0; org_x = 0; org_y = 0; end_x = 0; end_y = 0;
            err_term = 0; col_from = 0; col_to = 0; line_len_sq = 0;
            line_loaded = 1'b0;
            pixel_q.delete();
            o_errors = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[3:2])
                    glr_pkg::REG_PAN_X:         ofs_x = longint'($signed(i_pwdata[15:0]));
                    glr_pkg::REG_PAN_Y:         ofs_y = longint'($signed(i_pwdata[15:0]));
                    glr_pkg::REG_SCREEN_WIDTH:  scr_w = longint'(i_pwdata[13:0]);
                    glr_pkg::REG_SCREEN_HEIGHT: scr_h = longint'(i_pwdata[13:0]);
                    default: ;
                endcase
            end
            if (i_pop && !i_empty) begin
                if (pixel_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("unexpected pixel word x=%0d y=%0d",
                                                 i_pixel_x, i_pixel_y);
                end else begin
                    want = pixel_q.pop_front();
                    if (want !== {i_pixel_x, i_pixel_y, i_pixel_color, i_visible, i_last}) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch: exp %0d %0d %h %b %b, got %0d %0d %h %b %b",
                                     want.x, want.y, want.color, want.visible, want.last,
                                     i_pixel_x, i_pixel_y, i_pixel_color, i_visible, i_last);
                    end
                end
            end
            // The word is taken after the pop check so a same-edge pixel cannot match itself.
            if (i_push && !i_full) take_word();
        end
    end
endmodule

// ===== dv/gradient_line_rasterizer_core_tb.sv =====
// Stimulus and verdict for the gradient line rasterizer core.
module gradient_line_rasterizer_core_tb;

    localparam int CLK_HALF    = 6;
    // Margin for the color unit to drain once no pixel is pending.
    localparam int DRAIN_WAIT  = 120;
    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam bit MODE_LOAD   = 1'b0;
    localparam bit MODE_STEP   = 1'b1;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               push = 1'b0;
    logic               full;
    logic               i_mode = 1'b0;
    logic signed [15:0] i_start_x = '0, i_start_y = '0, i_stop_x = '0, i_stop_y = '0;
    logic [23:0]        i_start_color = '0, i_stop_color = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [16:0] o_pixel_x, o_pixel_y;
    logic [23:0]        o_pixel_color;
    logic               o_visible, o_last;

    int  pending, errors;
    int  cycles = 0;
    // Raised by the stimulus to ask the receiver for one long hold-off.
    bit  long_hold = 1'b0;
    // Turns off idling on both sides for the last part of the run.
    bit  quiet = 1'b0;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    gradient_line_rasterizer_core uut (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .push, .full, .i_mode, .i_start_x, .i_start_y, .i_stop_x, .i_stop_y,
        .i_start_color, .i_stop_color, .empty, .pop, .o_pixel_x, .o_pixel_y,
        .o_pixel_color, .o_visible, .o_last
    );

    glr_line_checker chk (
        .i_clk, .i_rst_n, .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite),
        .i_pready(pready), .i_paddr(paddr), .i_pwdata(pwdata), .i_push(push),
        .i_full(full), .i_mode, .i_start_x, .i_start_y, .i_stop_x, .i_stop_y,
        .i_start_color, .i_stop_color, .i_empty(empty), .i_pop(pop),
        .i_pixel_x(o_pixel_x), .i_pixel_y(o_pixel_y), .i_pixel_color(o_pixel_color),
        .i_visible(o_visible), .i_last(o_last), .o_pending(pending), .o_errors(errors)
    );

    // The run is cut off if it hangs anywhere.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // The receiver pops at random, with bursts of stall, and once holds off for a
    // long stretch so that the queue fills and the block stalls its input.
    initial begin
        bit held_once;
        held_once = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold && !held_once) begin
                held_once = 1'b1;
                pop = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                pop = 1'b0;
                repeat ($urandom_range(0, 7)) @(negedge i_clk);
            end else begin
                pop = 1'b1;
            end
        end
    end

    // Offers one word and holds it until the block takes it.
    task automatic send_word(bit mode, logic signed [15:0] sx, logic signed [15:0] sy,
                             logic signed [15:0] ex, logic signed [15:0] ey,
                             logic [23:0] sc, logic [23:0] ec);
        @(negedge i_clk);
        push = 1'b1;
        i_mode = mode;
        i_start_x = sx;
        i_start_y = sy;
        i_stop_x = ex;
        i_stop_y = ey;
        i_start_color = sc;
        i_stop_color = ec;
        do @(posedge i_clk); while (full);
        // Occasional sender gaps, so stalls land on every phase of the pixel math.
        if (!quiet && $urandom_range(0, 4) == 0) begin
            @(negedge i_clk);
            push = 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge i_clk);
        end
    endtask

    // A step word carries random junk in the fields that it does not use.
    task automatic send_step();
        send_word(MODE_STEP, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  24'($urandom), 24'($urandom));
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // Lowers push and lets every queued pixel drain before the setup changes.
    task automatic drain();
        @(negedge i_clk);
        push = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Loads a line, mostly a short one near a random point, and walks it, mostly to its end.
    task automatic random_line(inout int count);
        logic signed [15:0] bx, by, ex, ey;
        int len, steps;
        if ($urandom_range(0, 9) == 0) begin
            // Fully random endpoints: long lines, every coordinate bit toggles.
            bx = 16'($urandom); by = 16'($urandom); ex = 16'($urandom); ey = 16'($urandom);
            steps = $urandom_range(1, 6);
        end else begin
            bx = $signed(16'($urandom_range(0, 60000))) ;
            bx = (bx > 30000 || bx < -30000) ? 16'sd100 : bx;
            by = $signed(16'($urandom_range(0, 60000)));
            by = (by > 30000 || by < -30000) ? -16'sd50 : by;
            if ($urandom_range(0, 1)) begin
                bx = 16'($urandom_range(0, 40));
                by = 16'($urandom_range(0, 40));
            end
            ex = bx + $signed(5'($urandom_range(0, 31))) - 16'sd0;
            ey = by + $signed(5'($urandom_range(0, 31)));
            len = int'(ex > bx ? ex - bx : bx - ex) + int'(ey > by ? ey - by : by - ey);
            // Sometimes a new load cuts the walk short; sometimes steps run past the end.
            steps = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, len))
                                                : len + int'($urandom_range(0, 2));
        end
        send_word(MODE_LOAD, bx, by, ex, ey, 24'($urandom), 24'($urandom));
        count++;
        for (int i = 0; i < steps; i++) begin
            send_step();
            count++;
        end
    endtask

    initial begin
        int items;
        items = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, default screen setup.
        send_step();
        send_step();
        send_word(MODE_LOAD, 16'sd7, -16'sd3, 16'sd7, -16'sd3, 24'hFFFFFF, 24'h000000);
        send_step();
        send_step();
        send_word(MODE_LOAD, 16'sd0, 16'sd0, 16'sd3, 16'sd1, 24'hFFFFFF, 24'h000000);
        repeat (4) send_step();
        send_word(MODE_LOAD, 16'sd5, 16'sd5, 16'sd3, -16'sd1, 24'h000000, 24'hFFFFFF);
        repeat (7) send_step();
        send_word(MODE_LOAD, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
                  24'h00FF80, 24'hFF007F);
        repeat (3) send_step();
        drain();

        // Screen setups, the extremes among them, then random lines under each.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_reg(glr_pkg::REG_PAN_X, 32'hFFFF_8000);
                    write_reg(glr_pkg::REG_PAN_Y, 32'h0000_7FFF);
                    write_reg(glr_pkg::REG_SCREEN_WIDTH, 32'd8192);
                    write_reg(glr_pkg::REG_SCREEN_HEIGHT, 32'd1);
                end
                1: begin
                    write_reg(glr_pkg::REG_PAN_X, 32'd0);
                    write_reg(glr_pkg::REG_PAN_Y, 32'd0);
                    write_reg(glr_pkg::REG_SCREEN_WIDTH, 32'd0);
                    write_reg(glr_pkg::REG_SCREEN_HEIGHT, 32'd0);
                end
                2: begin
                    write_reg(glr_pkg::REG_PAN_X, 32'h0000_7FFF);
                    write_reg(glr_pkg::REG_PAN_Y, 32'hFFFF_8000);
                    write_reg(glr_pkg::REG_SCREEN_WIDTH, 32'd1);
                    write_reg(glr_pkg::REG_SCREEN_HEIGHT, 32'd8192);
                end
                default: begin
                    // Small offsets keep the walk near the screen edges.
                    write_reg(glr_pkg::REG_PAN_X, 32'($urandom_range(0, 40)) - 32'd20);
                    write_reg(glr_pkg::REG_PAN_Y, 32'($urandom_range(0, 40)) - 32'd20);
                    write_reg(glr_pkg::REG_SCREEN_WIDTH, $urandom_range(1, 60));
                    write_reg(glr_pkg::REG_SCREEN_HEIGHT, $urandom_range(1, 60));
                end
            endcase
            if (phase == 5) quiet = 1'b1;
            while (items < 72 * (phase + 1)) begin
                if (phase == 3 && items >= 72 * 3 + 10) long_hold = 1'b1;
                random_line(items);
            end
            drain();
        end

        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
